@@ src/kre_pkg.sv @@
// Shared types, constants and tables of the keypress rate estimator.
`default_nettype none

package kre_pkg;

  localparam int HISTORY_DEPTH = 60;
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W         = $clog2((HISTORY_DEPTH + 1) * 255 + 1);

  localparam int TIME_W  = 32;
  localparam int SEC_W   = 23;
  localparam int WIN_W   = 6;
  localparam int TMO_W   = 8;
  localparam int RATE_W  = 8;
  localparam int DIV_W   = 32;
  localparam int DVS_W   = 16;
  localparam int BLEND_W = 12;

  localparam int SEC_MS        = 1000;
  localparam int WPM_MUL       = 12;
  localparam int BLEND_NEW     = 7;
  localparam int BLEND_OLD     = 3;
  localparam int JUMP_LIM      = 50;
  localparam int DECAY_HOLD_MS = 5000;
  localparam int TMO_MIN       = 10;
  localparam int RATE_MAX      = 255;

  // floor(t / 1000) = (t * SEC_RECIP) >> SEC_SHIFT for any 32-bit t
  localparam int          SEC_SHIFT   = 38;
  localparam logic [28:0] SEC_RECIP   = 29'd274877907;
  // floor(b / 10) = (b * BLEND_RECIP) >> BLEND_SHIFT for any 12-bit b
  localparam int          BLEND_SHIFT = 15;
  localparam logic [11:0] BLEND_RECIP = 12'd3277;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE  = 2'd2;

  localparam logic CMD_KEY   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [TMO_W-1:0] timeout;
    logic             update_on_key;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] time_ms;
  } req_t;

  // whole windows per minute: floor(60 / window), zero for an empty window or one over 60
  function automatic logic [5:0] win_mult(input logic [WIN_W-1:0] w);
    logic [5:0] m;
    case (w) inside
      6'd1:           m = 6'd60;
      6'd2:           m = 6'd30;
      6'd3:           m = 6'd20;
      6'd4:           m = 6'd15;
      6'd5:           m = 6'd12;
      6'd6:           m = 6'd10;
      6'd7:           m = 6'd8;
      6'd8:           m = 6'd7;
      [6'd9:6'd10]:   m = 6'd6;
      [6'd11:6'd12]:  m = 6'd5;
      [6'd13:6'd15]:  m = 6'd4;
      [6'd16:6'd20]:  m = 6'd3;
      [6'd21:6'd30]:  m = 6'd2;
      [6'd31:6'd60]:  m = 6'd1;
      default:        m = 6'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ src/kre_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/kre_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module kre_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic [kre_pkg::DIV_W-1:0] dividend,
  input  wire logic [kre_pkg::DVS_W-1:0] divisor,
  output logic                           done,
  output logic      [kre_pkg::DIV_W-1:0] quot
);

  localparam int DC_W = $clog2(kre_pkg::DIV_W + 1);

  logic                      busy_r;
  logic [DC_W-1:0]           cnt_r;
  logic                      done_r;
  logic [kre_pkg::DIV_W-1:0] sh_r;
  logic [kre_pkg::DVS_W-1:0] rem_r;
  logic [kre_pkg::DVS_W-1:0] dvs_r;
  logic [kre_pkg::DVS_W:0]   trial;
  logic                      ge;

  always_comb begin
    trial = {rem_r, sh_r[kre_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= DC_W'(kre_pkg::DIV_W);
        sh_r   <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? kre_pkg::DVS_W'(trial - {1'b0, dvs_r})
                    : trial[kre_pkg::DVS_W-1:0];
        sh_r  <= {sh_r[kre_pkg::DIV_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

`default_nettype wire

@@ src/kre_core.sv @@
// Sequencer: ring advance, window sum, rate estimate, idle clear and decay.
`default_nettype none

module kre_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire kre_pkg::cfg_t              cfg,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire kre_pkg::req_t              req,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output logic      [kre_pkg::RATE_W-1:0] res_rate
);

  localparam int DEPTH = kre_pkg::HISTORY_DEPTH;
  localparam int PTR_W = kre_pkg::PTR_W;
  localparam int CNT_W = kre_pkg::CNT_W;
  localparam int SUM_W = kre_pkg::SUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SEC, S_CMD, S_ADV, S_KINC, S_EST, S_SUM, S_RAW,
    S_RAWW, S_BLW, S_IDL0, S_IDL1, S_DEC, S_DECW, S_OUT
  } state_t;

  state_t                     state_r;
  logic                       cmd_r;
  logic [kre_pkg::TIME_W-1:0] now_r;
  logic [kre_pkg::SEC_W-1:0]  sec_r;
  logic [kre_pkg::SEC_W-1:0]  lss_r;
  logic [kre_pkg::TIME_W-1:0] lkt_r;
  logic [7:0]                 kts_r;
  logic [kre_pkg::RATE_W-1:0] rate_r;
  logic [PTR_W-1:0]           pos_r;
  logic [PTR_W-1:0]           rd_ptr_r;
  logic [DEPTH-1:0]           vld_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       first_r;
  logic                       ret_est_r;
  logic                       pend_r;
  logic                       hit_r;
  logic [SUM_W-1:0]           acc_r;
  logic [kre_pkg::TIME_W-1:0] idle_r;
  logic [15:0]                rem_r;
  logic [kre_pkg::DIV_W-1:0]  dvd_r;
  logic [kre_pkg::DVS_W-1:0]  dvs_r;
  logic                       div_go_r;
  logic [kre_pkg::BLEND_W-1:0] blend_r;

  logic                       div_done;
  logic [kre_pkg::DIV_W-1:0]  div_quot;
  logic [7:0]                 ram_rdata;
  logic                       ram_we;
  logic [7:0]                 ram_wdata;

  logic [PTR_W-1:0]           pos_inc;
  logic [PTR_W-1:0]           rd_dec;
  logic [31:0]                elapsed;
  logic [CNT_W-1:0]           adv_n;
  logic [CNT_W-1:0]           sum_n;
  logic [SUM_W+3:0]           acc12;
  logic [kre_pkg::DIV_W-1:0]  raw_prod;
  logic [kre_pkg::DIV_W-1:0]  diff;
  logic [kre_pkg::BLEND_W-1:0] blend;
  logic [15:0]                wms;
  logic [17:0]                tmo;
  logic [kre_pkg::TIME_W-1:0] over;
  logic [kre_pkg::DIV_W-1:0]  dec_prod;
  logic [kre_pkg::RATE_W-1:0] quot_sat;
  logic [60:0]                sec_prod;
  logic [23:0]                blend_prod;
  logic [kre_pkg::RATE_W-1:0] blend_sat;

  kre_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_inc),
    .wdata (ram_wdata),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  kre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    pos_inc   = (pos_r == PTR_W'(DEPTH - 1)) ? '0 : pos_r + 1'b1;
    rd_dec    = (rd_ptr_r == '0) ? PTR_W'(DEPTH - 1) : rd_ptr_r - 1'b1;
    elapsed   = 32'(sec_r) - 32'(lss_r);
    adv_n     = (elapsed < 32'(DEPTH)) ? CNT_W'(elapsed) : CNT_W'(DEPTH);
    sum_n     = (32'(cfg.window) < 32'(DEPTH)) ? CNT_W'(cfg.window) : CNT_W'(DEPTH);
    ram_we    = (state_r == S_ADV);
    ram_wdata = first_r ? kts_r : 8'd0;
    acc12     = (SUM_W + 4)'(acc_r) * (SUM_W + 4)'(kre_pkg::WPM_MUL);
    raw_prod  = 32'(acc12) * 32'(kre_pkg::win_mult(cfg.window));
    diff      = (div_quot > 32'(rate_r)) ? div_quot - 32'(rate_r)
                                         : 32'(rate_r) - div_quot;
    blend     = kre_pkg::BLEND_W'(div_quot[8:0]) * kre_pkg::BLEND_W'(kre_pkg::BLEND_NEW)
              + kre_pkg::BLEND_W'(rate_r) * kre_pkg::BLEND_W'(kre_pkg::BLEND_OLD);
    wms       = 16'(cfg.window) * 16'(kre_pkg::SEC_MS);
    tmo       = (32'(cfg.timeout) >= 32'(kre_pkg::TMO_MIN))
                ? 18'(cfg.timeout) * 18'(kre_pkg::SEC_MS) : {1'b0, wms, 1'b0};
    over      = idle_r - 32'(kre_pkg::DECAY_HOLD_MS);
    dec_prod  = 32'(rate_r) * 32'(rem_r);
    quot_sat  = (div_quot > 32'(kre_pkg::RATE_MAX)) ? kre_pkg::RATE_W'(kre_pkg::RATE_MAX)
                                                     : div_quot[kre_pkg::RATE_W-1:0];
    sec_prod  = 61'(now_r) * 61'(kre_pkg::SEC_RECIP);
    blend_prod = 24'(blend_r) * 24'(kre_pkg::BLEND_RECIP);
    blend_sat  = (blend_prod[23:kre_pkg::BLEND_SHIFT] > 9'(kre_pkg::RATE_MAX))
                 ? kre_pkg::RATE_W'(kre_pkg::RATE_MAX)
                 : blend_prod[kre_pkg::BLEND_SHIFT +: kre_pkg::RATE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lss_r     <= '0;
      lkt_r     <= '0;
      kts_r     <= '0;
      rate_r    <= '0;
      pos_r     <= '0;
      vld_r     <= '0;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      div_go_r  <= 1'b0;
      first_r   <= 1'b0;
      ret_est_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            cmd_r   <= req.command;
            now_r   <= req.time_ms;
            state_r <= S_SEC;
          end
        end
        S_SEC: begin
          sec_r   <= sec_prod[kre_pkg::SEC_SHIFT +: kre_pkg::SEC_W];
          state_r <= S_CMD;
        end
        S_CMD: begin
          if (cmd_r == kre_pkg::CMD_KEY) begin
            lkt_r <= now_r;
            if (sec_r != lss_r) begin
              cnt_r     <= adv_n;
              first_r   <= 1'b1;
              ret_est_r <= 1'b0;
              state_r   <= S_ADV;
            end else begin
              state_r <= S_KINC;
            end
          end else begin
            state_r <= S_EST;
          end
        end
        S_ADV: begin
          vld_r[pos_inc] <= 1'b1;
          pos_r          <= pos_inc;
          first_r        <= 1'b0;
          cnt_r          <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            lss_r   <= sec_r;
            kts_r   <= '0;
            state_r <= ret_est_r ? S_EST : S_KINC;
          end
        end
        S_KINC: begin
          if (kts_r != 8'hFF) begin
            kts_r <= kts_r + 1'b1;
          end
          state_r <= cfg.update_on_key ? S_EST : S_IDLE;
        end
        S_EST: begin
          if (sec_r != lss_r && lss_r != '0) begin
            cnt_r     <= adv_n;
            first_r   <= 1'b1;
            ret_est_r <= 1'b1;
            state_r   <= S_ADV;
          end else begin
            if (lss_r == '0) begin
              lss_r <= sec_r;
            end
            cnt_r    <= sum_n;
            rd_ptr_r <= pos_r;
            acc_r    <= SUM_W'(kts_r);
            pend_r   <= 1'b0;
            state_r  <= S_SUM;
          end
        end
        S_SUM: begin
          if (pend_r && hit_r) begin
            acc_r <= acc_r + SUM_W'(ram_rdata);
          end
          pend_r <= (cnt_r != '0);
          if (cnt_r != '0) begin
            hit_r    <= vld_r[rd_ptr_r];
            rd_ptr_r <= rd_dec;
            cnt_r    <= cnt_r - 1'b1;
          end else if (!pend_r) begin
            state_r <= S_RAW;
          end
        end
        S_RAW: begin
          if (cfg.window != '0 && acc_r != '0) begin
            dvd_r    <= raw_prod;
            dvs_r    <= kre_pkg::DVS_W'(cfg.window);
            div_go_r <= 1'b1;
            state_r  <= S_RAWW;
          end else begin
            state_r <= S_IDL0;
          end
        end
        S_RAWW: begin
          if (div_done) begin
            if (rate_r == '0 || diff > 32'(kre_pkg::JUMP_LIM)) begin
              rate_r  <= quot_sat;
              state_r <= S_IDL0;
            end else begin
              blend_r <= blend;
              state_r <= S_BLW;
            end
          end
        end
        S_BLW: begin
          rate_r  <= blend_sat;
          state_r <= S_IDL0;
        end
        S_IDL0: begin
          idle_r  <= now_r - lkt_r;
          state_r <= S_IDL1;
        end
        S_IDL1: begin
          if (idle_r > 32'(tmo)) begin
            rate_r  <= '0;
            vld_r   <= '0;
            pos_r   <= '0;
            kts_r   <= '0;
            lss_r   <= '0;
            state_r <= S_OUT;
          end else if (idle_r > 32'(kre_pkg::DECAY_HOLD_MS) && rate_r != '0) begin
            if (wms == '0 || over >= 32'(wms)) begin
              rate_r  <= '0;
              state_r <= S_OUT;
            end else begin
              rem_r   <= wms - over[15:0];
              dvs_r   <= kre_pkg::DVS_W'(wms);
              state_r <= S_DEC;
            end
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DEC: begin
          dvd_r    <= dec_prod;
          div_go_r <= 1'b1;
          state_r  <= S_DECW;
        end
        S_DECW: begin
          if (div_done) begin
            rate_r  <= div_quot[kre_pkg::RATE_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_rate  = rate_r;

endmodule

`default_nettype wire

@@ src/keypress_rate_estimator_top.sv @@
// Top level of the keypress rate estimator: ports, configuration, output register.
//
//  channel | ports                         | moves
//  --------+-------------------------------+------------------------------------
//  in      | in_tvalid/in_tready           | tuser: command; tdata: time_ms
//  out     | out_tvalid/out_tready         | tdata: rate_wpm
//  cfg     | cfg_valid/cfg_ready           | cfg_index, cfg_data (always ready)
//
// An item splits time_ms into seconds (reciprocal multiply), then as needed
// advances the ring by up to 60 slots (one slot write per cycle), sums up to
// 60 slots of the window (one ring read per cycle), divides by the window (raw
// rate) or by the window length in ms (decay) on the shared bit-serial divider
// and blends the new rate with the old.
// Reset clears the ring through per-slot valid bits.
// A result waits in the output register while the next request is taken.
`default_nettype none

module keypress_rate_estimator_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [kre_pkg::TIME_W-1:0]      in_tdata,   // [31:0] time_ms
  input  wire logic                            in_tuser,   // [0] command
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [kre_pkg::RATE_W-1:0]      out_tdata,  // [7:0] rate_wpm
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [kre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kre_pkg::CFG_DATA_W-1:0]  cfg_data
);

  kre_pkg::cfg_t              cfg_r;
  kre_pkg::req_t              req;
  logic                       out_valid_r;
  logic [kre_pkg::RATE_W-1:0] out_data_r;
  logic                       res_valid;
  logic                       res_ready;
  logic [kre_pkg::RATE_W-1:0] res_rate;

  assign req.command = in_tuser;
  assign req.time_ms = in_tdata;
  assign res_ready   = !out_valid_r || out_tready;
  assign cfg_ready   = 1'b1;

  kre_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_rate  (res_rate)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window        <= kre_pkg::WIN_W'(30);
      cfg_r.timeout       <= '0;
      cfg_r.update_on_key <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        kre_pkg::CFG_WINDOW:  cfg_r.window        <= cfg_data[kre_pkg::WIN_W-1:0];
        kre_pkg::CFG_TIMEOUT: cfg_r.timeout       <= cfg_data[kre_pkg::TMO_W-1:0];
        kre_pkg::CFG_UPDATE:  cfg_r.update_on_key <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res_rate;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
